[hw/rtl/lrul_pkg.sv]
`default_nettype none

package lrul_pkg;

    // Table size, port field widths and microprogram address width
    localparam int LRUL_ENTRIES = 256;
    localparam int CMD_W        = 2;
    localparam int IDX_W        = 8;
    localparam int STAT_W       = 2;
    localparam int PTR_W        = 9;
    localparam int UPC_W        = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_POP    = 2'd2,
        CMD_MOVE   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    // Microcode fields
    typedef enum logic [1:0] {
        SEQ_NEXT = 2'd0,
        SEQ_DISP = 2'd1,
        SEQ_END  = 2'd2
    } t_seq_op;

    typedef enum logic [1:0] {
        PW_NONE        = 2'd0,
        PW_N_GETS_P    = 2'd1,
        PW_E_CLR       = 2'd2,
        PW_HEAD_GETS_E = 2'd3
    } t_prev_op;

    typedef enum logic [1:0] {
        NW_NONE        = 2'd0,
        NW_P_GETS_N    = 2'd1,
        NW_E_GETS_HEAD = 2'd2
    } t_next_op;

    typedef enum logic [1:0] {
        PTR_KEEP   = 2'd0,
        PTR_UNLINK = 2'd1,
        PTR_FRONT  = 2'd2
    } t_ptr_op;

    typedef enum logic [1:0] {
        FLG_KEEP = 2'd0,
        FLG_SET  = 2'd1,
        FLG_CLR  = 2'd2
    } t_flag_op;

    typedef enum logic [1:0] {
        CNT_KEEP = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } t_cnt_op;

    typedef struct packed {
        logic     rd;
        t_prev_op prev_op;
        t_next_op next_op;
        t_ptr_op  head_op;
        t_ptr_op  tail_op;
        t_flag_op flag_op;
        t_cnt_op  cnt_op;
        t_seq_op  seq;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic   act;
        t_uword uw;
    } t_ctl;

    // Datapath to sequencer, sampled at dispatch
    typedef struct packed {
        t_cmd cmd;
        logic misuse;
        logic empty;
        logic at_head;
    } t_cond;

    // Microprogram addresses
    localparam logic [UPC_W-1:0] UA_DISP = 3'd0;
    localparam logic [UPC_W-1:0] UA_FIN  = 3'd1;
    localparam logic [UPC_W-1:0] UA_UNL  = 3'd2;
    localparam logic [UPC_W-1:0] UA_MVU  = 3'd3;
    localparam logic [UPC_W-1:0] UA_LK1  = 3'd4;
    localparam logic [UPC_W-1:0] UA_LK2  = 3'd5;

    // Control store
    function automatic t_uword lrul_urom(input logic [UPC_W-1:0] upc);
        t_uword w;
        w = '{rd: 1'b0, prev_op: PW_NONE, next_op: NW_NONE, head_op: PTR_KEEP,
              tail_op: PTR_KEEP, flag_op: FLG_KEEP, cnt_op: CNT_KEEP, seq: SEQ_END};
        unique case (upc)
            UA_DISP: begin
                w.rd  = 1'b1;
                w.seq = SEQ_DISP;
            end
            UA_FIN: begin
                w.seq = SEQ_END;
            end
            UA_UNL, UA_MVU: begin
                w.prev_op = PW_N_GETS_P;
                w.next_op = NW_P_GETS_N;
                w.head_op = PTR_UNLINK;
                w.tail_op = PTR_UNLINK;
                w.flag_op = FLG_CLR;
                w.cnt_op  = CNT_DEC;
                w.seq     = (upc == UA_MVU) ? SEQ_NEXT : SEQ_END;
            end
            UA_LK1: begin
                w.prev_op = PW_E_CLR;
                w.next_op = NW_E_GETS_HEAD;
                w.flag_op = FLG_SET;
                w.seq     = SEQ_NEXT;
            end
            UA_LK2: begin
                w.prev_op = PW_HEAD_GETS_E;
                w.head_op = PTR_FRONT;
                w.tail_op = PTR_FRONT;
                w.cnt_op  = CNT_INC;
                w.seq     = SEQ_END;
            end
            default: begin
                w.seq = SEQ_END;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lrul_seq.sv]
`default_nettype none

module lrul_seq
    import lrul_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_cond i_cond,
    input  wire logic  i_out_free,
    output logic       o_busy,
    output t_ctl       o_ctl
);

    logic             r_busy;
    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] disp_target;
    t_uword           uw;
    logic             act;
    logic             end_blocked;

    // Fetch the current control word
    assign uw          = lrul_urom(r_upc);
    assign end_blocked = (uw.seq == SEQ_END) && !i_out_free;
    assign act         = r_busy && !end_blocked;

    assign o_busy    = r_busy;
    assign o_ctl.act = act;
    assign o_ctl.uw  = uw;

    // Pick the routine for the command
    always_comb begin
        if (i_cond.misuse || ((i_cond.cmd == CMD_POP) && i_cond.empty)
                || ((i_cond.cmd == CMD_MOVE) && i_cond.at_head)) begin
            disp_target = UA_FIN;
        end else begin
            unique case (i_cond.cmd)
                CMD_INSERT: disp_target = UA_LK1;
                CMD_REMOVE: disp_target = UA_UNL;
                CMD_POP:    disp_target = UA_UNL;
                CMD_MOVE:   disp_target = UA_MVU;
            endcase
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= UA_DISP;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_upc  <= UA_DISP;
        end else if (act) begin
            unique case (uw.seq)
                SEQ_NEXT: r_upc  <= r_upc + 1'b1;
                SEQ_DISP: r_upc  <= disp_target;
                SEQ_END:  r_busy <= 1'b0;
                default:  r_busy <= 1'b0;
            endcase
        end
    end

    a_start_at_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && (r_upc == UA_DISP)))
        else $error("sequencer did not enter dispatch after accept");

    a_end_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && end_blocked && !i_start) |=> (r_busy && $stable(r_upc)))
        else $error("final step left while result register was full");

endmodule

`default_nettype wire

[hw/rtl/lrul_dp.sv]
`default_nettype none

module lrul_dp
    import lrul_pkg::*;
#(
    parameter int ENTRIES = LRUL_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [IDX_W-1:0]  i_entry_index,
    input  wire t_ctl              i_ctl,
    input  wire logic              i_stall,
    output t_cond                  o_cond,
    output logic                   o_out_free,
    output logic                   o_valid,
    output logic [STAT_W-1:0]      o_status,
    output logic [IDX_W-1:0]       o_victim_index,
    output logic                   o_victim_valid,
    output logic [PTR_W-1:0]       o_entry_count,
    output logic [PTR_W-1:0]       o_head_entry,
    output logic [PTR_W-1:0]       o_tail_entry
);

    // Only indices that fit the index field can ever be listed
    localparam int DEPTH = (ENTRIES < (1 << IDX_W)) ? ENTRIES : (1 << IDX_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(ENTRIES + 1);
    localparam logic [LW-1:0] NONE_L = LW'(ENTRIES);

    t_cmd            r_cmd;
    logic [AW-1:0]   r_e;
    logic            r_in_range;
    t_status         r_status;
    logic [LW-1:0]   r_head;
    logic [LW-1:0]   r_tail;
    logic [LW-1:0]   r_count;
    logic [DEPTH-1:0] r_flag;
    logic [LW-1:0]   r_prev_mem [DEPTH];
    logic [LW-1:0]   r_next_mem [DEPTH];
    logic [LW-1:0]   r_prev_rd;
    logic [LW-1:0]   r_next_rd;

    logic            r_out_valid;
    t_status         r_out_status;
    logic [IDX_W-1:0] r_out_victim;
    logic            r_out_vvalid;
    logic [PTR_W-1:0] r_out_count;
    logic [PTR_W-1:0] r_out_head;
    logic [PTR_W-1:0] r_out_tail;

    logic [LW-1:0]   n_head;
    logic [LW-1:0]   n_tail;
    logic [LW-1:0]   n_count;
    logic [LW-1:0]   e_l;
    logic            p_ok;
    logic            n_ok;
    logic            head_ok;
    logic            listed;
    logic            misuse;
    logic            prev_we;
    logic [AW-1:0]   prev_wa;
    logic [LW-1:0]   prev_wd;
    logic            next_we;
    logic [AW-1:0]   next_wa;
    logic [LW-1:0]   next_wd;
    logic            act;
    logic            out_load;
    t_uword          uw;

    assign act      = i_ctl.act;
    assign uw       = i_ctl.uw;
    assign out_load = act && (uw.seq == SEQ_END);

    assign e_l     = LW'(r_e);
    assign p_ok    = (r_prev_rd != NONE_L);
    assign n_ok    = (r_next_rd != NONE_L);
    assign head_ok = (r_head != NONE_L);
    assign listed  = r_in_range && r_flag[r_e];

    // Check the command against membership
    always_comb begin
        unique case (r_cmd)
            CMD_INSERT: misuse = !r_in_range || listed;
            CMD_REMOVE: misuse = !listed;
            CMD_POP:    misuse = 1'b0;
            CMD_MOVE:   misuse = !listed;
        endcase
    end

    assign o_cond.cmd     = r_cmd;
    assign o_cond.misuse  = misuse;
    assign o_cond.empty   = (r_tail == NONE_L);
    assign o_cond.at_head = (e_l == r_head);

    // Decode link memory writes
    always_comb begin
        prev_we = 1'b0;
        prev_wa = r_e;
        prev_wd = NONE_L;
        next_we = 1'b0;
        next_wa = r_e;
        next_wd = NONE_L;
        if (act) begin
            unique case (uw.prev_op)
                PW_NONE: begin
                    prev_we = 1'b0;
                end
                PW_N_GETS_P: begin
                    prev_we = n_ok;
                    prev_wa = r_next_rd[AW-1:0];
                    prev_wd = r_prev_rd;
                end
                PW_E_CLR: begin
                    prev_we = 1'b1;
                end
                PW_HEAD_GETS_E: begin
                    prev_we = head_ok;
                    prev_wa = r_head[AW-1:0];
                    prev_wd = e_l;
                end
            endcase
            unique case (uw.next_op)
                NW_P_GETS_N: begin
                    next_we = p_ok;
                    next_wa = r_prev_rd[AW-1:0];
                    next_wd = r_next_rd;
                end
                NW_E_GETS_HEAD: begin
                    next_we = 1'b1;
                    next_wd = r_head;
                end
                default: begin
                    next_we = 1'b0;
                end
            endcase
        end
    end

    // Next head, tail and count
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (act) begin
            unique case (uw.head_op)
                PTR_UNLINK: if (!p_ok) n_head = r_next_rd;
                PTR_FRONT:  n_head = e_l;
                default:    n_head = r_head;
            endcase
            unique case (uw.tail_op)
                PTR_UNLINK: if (!n_ok) n_tail = r_prev_rd;
                PTR_FRONT:  if (!head_ok) n_tail = e_l;
                default:    n_tail = r_tail;
            endcase
            unique case (uw.cnt_op)
                CNT_INC: n_count = r_count + 1'b1;
                CNT_DEC: n_count = r_count - 1'b1;
                default: n_count = r_count;
            endcase
        end
    end

    // Link memories with registered read
    always_ff @(posedge i_clk) begin
        if (prev_we) r_prev_mem[prev_wa] <= prev_wd;
        if (next_we) r_next_mem[next_wa] <= next_wd;
        if (act && uw.rd) begin
            r_prev_rd <= r_prev_mem[r_e];
            r_next_rd <= r_next_mem[r_e];
        end
    end

    // Latch the transaction; pop works on the tail
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_e        <= (t_cmd'(i_cmd) == CMD_POP) ? r_tail[AW-1:0]
                                                      : i_entry_index[AW-1:0];
            r_in_range <= (32'(i_entry_index) < 32'(ENTRIES));
        end
        if (act && (uw.seq == SEQ_DISP)) begin
            if (misuse) begin
                r_status <= ST_REJECT;
            end else if ((r_cmd == CMD_POP) && o_cond.empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_DONE;
            end
        end
    end

    // List state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= NONE_L;
            r_tail  <= NONE_L;
            r_count <= '0;
            r_flag  <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (act && (uw.flag_op == FLG_SET)) r_flag[r_e] <= 1'b1;
            if (act && (uw.flag_op == FLG_CLR)) r_flag[r_e] <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_vvalid <= (r_cmd == CMD_POP) && (r_status == ST_DONE);
            r_out_victim <= ((r_cmd == CMD_POP) && (r_status == ST_DONE))
                            ? IDX_W'(r_e) : '0;
            r_out_count  <= PTR_W'(n_count);
            r_out_head   <= PTR_W'(n_head);
            r_out_tail   <= PTR_W'(n_tail);
        end
    end

    assign o_out_free     = !r_out_valid || !i_stall;
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_victim_index = r_out_victim;
    assign o_victim_valid = r_out_vvalid;
    assign o_entry_count  = r_out_count;
    assign o_head_entry   = r_out_head;
    assign o_tail_entry   = r_out_tail;

    a_head_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NONE_L) == (r_count == '0))
        else $error("head pointer disagrees with entry count");

    a_tail_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail == NONE_L) == (r_count == '0))
        else $error("tail pointer disagrees with entry count");

    a_victim_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_vvalid) |-> (r_out_status == ST_DONE))
        else $error("victim reported with a failing status");

endmodule

`default_nettype wire

[hw/rtl/lru_doubly_linked_order_list.sv]
// Recency list over a table of entries, kept as a doubly linked list.
// Input channel (i_valid / o_stall) carries one command per transaction:
// insert at front, remove, pop least recent, or move to front, with the
// entry index. Output channel (o_valid / i_stall) returns one result per
// command: status, the popped entry, and the count, head and tail after it.
// A small microprogram sequences each command over shared link memories
// (one write port each, registered read), one control word per cycle
// unless held at the last step. After dispatch, a finish step ends
// misuse, empty pop and move of head; remove and pop take an unlink step,
// insert two link steps, move all three. The last step loads the result,
// offered from the cycle after the load. The dependent link read and the
// single write port per link memory set these step counts. A new command
// can be accepted in the cycle after the previous one has loaded its
// result, even while that result is still stalled at the output. When the
// output is stalled with a result waiting, the next command runs up to
// its last step and holds there. Reset (synchronous, active low) empties
// the list: head and tail read 256 (none), count zero; no memory clearing
// pass is needed, as links are only read for listed entries.
`default_nettype none

module lru_doubly_linked_order_list
    import lrul_pkg::*;
#(
    parameter int ENTRIES = LRUL_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [IDX_W-1:0]  i_entry_index,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [STAT_W-1:0]      o_status,
    output logic [IDX_W-1:0]       o_victim_index,
    output logic                   o_victim_valid,
    output logic [PTR_W-1:0]       o_entry_count,
    output logic [PTR_W-1:0]       o_head_entry,
    output logic [PTR_W-1:0]       o_tail_entry
);

    logic  busy;
    logic  start;
    logic  out_free;
    t_ctl  ctl;
    t_cond cond;

    assign o_stall = busy;
    assign start   = i_valid && !busy;

    lrul_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cond     (cond),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctl      (ctl)
    );

    lrul_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_cmd          (i_cmd),
        .i_entry_index  (i_entry_index),
        .i_ctl          (ctl),
        .i_stall        (i_stall),
        .o_cond         (cond),
        .o_out_free     (out_free),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_victim_index (o_victim_index),
        .o_victim_valid (o_victim_valid),
        .o_entry_count  (o_entry_count),
        .o_head_entry   (o_head_entry),
        .o_tail_entry   (o_tail_entry)
    );

endmodule

`default_nettype wire
